// ----- src/mwrd_pkg.sv -----
// Shared types and constants of the multi-window request dropper.
`timescale 1ns / 1ps

package mwrd_pkg;

  localparam int unsigned TimeW     = 30;
  localparam int unsigned LimitW    = 16;
  localparam int unsigned TotalW    = 24;
  localparam int unsigned RingAw    = 6;
  localparam int unsigned RingDepth = 64;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned CfgAw     = 2;

  localparam logic [LimitW-1:0] LimitOneRst   = 16'd3;
  localparam logic [LimitW-1:0] LimitShortRst = 16'd20;
  localparam logic [LimitW-1:0] LimitLongRst  = 16'd60;
  localparam logic [TotalW-1:0] TotalMax      = {TotalW{1'b1}};

  typedef enum logic [CfgAw-1:0] {
    CfgLimitOne   = 2'd0,
    CfgLimitShort = 2'd1,
    CfgLimitLong  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [LimitW-1:0] one_sec;
    logic [LimitW-1:0] short_win;
    logic [LimitW-1:0] long_win;
  } limits_t;

  typedef struct packed {
    logic              jump;
    logic [RingAw-1:0] gap;
    logic [RingAw-1:0] slot;
  } req_entry_t;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StRetire = 5'b00010,
    StClear  = 5'b00100,
    StRead   = 5'b01000,
    StExec   = 5'b10000
  } back_state_e;

endpackage

// ----- src/mwrd_front.sv -----
// Front end: accepts request beats and classifies the time step.
`timescale 1ns / 1ps

module mwrd_front #(
  parameter int unsigned LONG_WINDOW = 60
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mwrd_pkg::TimeW-1:0]       in_time_i,
  input  logic                             full_i,
  output logic                             push_o,
  output mwrd_pkg::req_entry_t             entry_o
);

  localparam logic [mwrd_pkg::TimeW-1:0] LongSpan = mwrd_pkg::TimeW'(LONG_WINDOW);

  logic [mwrd_pkg::TimeW-1:0] last_q, last_d;
  logic [mwrd_pkg::TimeW-1:0] t_eff;
  logic [mwrd_pkg::TimeW-1:0] gap;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Clamp a time that goes backwards to the last second.
  assign t_eff = (in_time_i > last_q) ? in_time_i : last_q;
  assign gap   = t_eff - last_q;

  assign entry_o.jump = (gap >= LongSpan);
  assign entry_o.gap  = gap[mwrd_pkg::RingAw-1:0];
  assign entry_o.slot = t_eff[mwrd_pkg::RingAw-1:0];

  assign last_d = push_o ? t_eff : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

// ----- src/mwrd_fifo.sv -----
// Short queue of classified requests between front and back.
`timescale 1ns / 1ps

module mwrd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mwrd_pkg::req_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output mwrd_pkg::req_entry_t head_o
);

  localparam int unsigned PtrW = $clog2(mwrd_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(mwrd_pkg::FifoDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(mwrd_pkg::FifoDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(mwrd_pkg::FifoDepth - 1);

  mwrd_pkg::req_entry_t store_q [mwrd_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/mwrd_back.sv -----
// Back end: retires elapsed seconds, counts requests and decides drops.
`timescale 1ns / 1ps

module mwrd_back #(
  parameter int unsigned SHORT_WINDOW = 10,
  parameter int unsigned LONG_WINDOW  = 60,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mwrd_pkg::limits_t            limits_i,
  input  logic                         head_valid_i,
  input  mwrd_pkg::req_entry_t         head_i,
  output logic                         pop_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic                         res_dropped_o,
  output logic [mwrd_pkg::TotalW-1:0]  res_total_o
);

  localparam int unsigned RingAw    = mwrd_pkg::RingAw;
  localparam int unsigned ShortSumW = COUNT_WIDTH + $clog2(SHORT_WINDOW);
  localparam int unsigned LongSumW  = COUNT_WIDTH + $clog2(LONG_WINDOW);
  localparam int unsigned CmpW      =
    ((LongSumW > mwrd_pkg::LimitW) ? LongSumW : mwrd_pkg::LimitW) + 1;
  localparam logic [RingAw-1:0]      ShortOff = RingAw'(SHORT_WINDOW);
  localparam logic [RingAw-1:0]      LongOff  = RingAw'(LONG_WINDOW);
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  mwrd_pkg::back_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0] ring_q [mwrd_pkg::RingDepth];
  logic [mwrd_pkg::RingDepth-1:0] valid_q, valid_d;

  logic [RingAw-1:0] slot_q, slot_d, step_q, step_d, cnt_q, cnt_d;
  logic [RingAw-1:0] rd_addr_a, rd_addr_b;
  logic              rd_en_a, rd_en_b;
  logic [COUNT_WIDTH-1:0] rd_a_q, rd_b_q;
  logic              va_q, vb_q;
  logic              ret_pend_q, ret_pend_d;
  logic              clr_one, clr_all, fire;

  logic [ShortSumW-1:0] short_q, short_d;
  logic [LongSumW-1:0]  long_q, long_d;
  logic [mwrd_pkg::TotalW-1:0] total_q, total_d;

  logic                        out_valid_q, out_valid_d, out_drop_q;
  logic [mwrd_pkg::TotalW-1:0] out_total_q;
  logic                        out_free;

  logic [COUNT_WIDTH-1:0] here;
  logic                   here_sat, drop;

  assign out_free = !out_valid_q || res_ready_i;
  assign here     = va_q ? rd_a_q : '0;
  assign here_sat = (here == CountMax);

  assign drop = ((CmpW'(here) + 1'b1) > CmpW'(limits_i.one_sec)) ||
                ((CmpW'(short_q) + 1'b1) > CmpW'(limits_i.short_win)) ||
                ((CmpW'(long_q) + 1'b1) > CmpW'(limits_i.long_win));

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    rd_en_a   = 1'b0;
    rd_en_b   = 1'b0;
    rd_addr_a = slot_q;
    rd_addr_b = step_q - LongOff;
    clr_one   = 1'b0;
    clr_all   = 1'b0;
    fire      = 1'b0;
    slot_d    = slot_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    unique case (state_q)
      mwrd_pkg::StIdle: begin
        if (head_valid_i) begin
          pop_o  = 1'b1;
          slot_d = head_i.slot;
          step_d = head_i.slot - head_i.gap + 1'b1;
          cnt_d  = head_i.gap;
          if (head_i.jump) begin
            state_d = mwrd_pkg::StClear;
          end else if (head_i.gap == '0) begin
            rd_en_a   = 1'b1;
            rd_addr_a = head_i.slot;
            state_d   = mwrd_pkg::StExec;
          end else begin
            state_d = mwrd_pkg::StRetire;
          end
        end
      end
      mwrd_pkg::StRetire: begin
        rd_en_a   = 1'b1;
        rd_en_b   = 1'b1;
        rd_addr_a = step_q - ShortOff;
        clr_one   = 1'b1;
        step_d    = step_q + 1'b1;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == RingAw'(1)) begin
          state_d = mwrd_pkg::StRead;
        end
      end
      mwrd_pkg::StClear: begin
        clr_all = 1'b1;
        state_d = mwrd_pkg::StRead;
      end
      mwrd_pkg::StRead: begin
        rd_en_a = 1'b1;
        state_d = mwrd_pkg::StExec;
      end
      mwrd_pkg::StExec: begin
        if (out_free) begin
          fire    = 1'b1;
          state_d = mwrd_pkg::StIdle;
        end
      end
      default: begin
        state_d = mwrd_pkg::StIdle;
      end
    endcase
  end

  // Take retired seconds out of the window sums from the registered read data, flagged by ret_pend_q.
  always_comb begin
    short_d    = short_q;
    long_d     = long_q;
    total_d    = total_q;
    valid_d    = valid_q;
    ret_pend_d = rd_en_b;
    if (ret_pend_q) begin
      short_d = short_q - (va_q ? ShortSumW'(rd_a_q) : '0);
      long_d  = long_q - (vb_q ? LongSumW'(rd_b_q) : '0);
    end
    if (clr_one) begin
      valid_d[step_q] = 1'b0;
    end
    if (clr_all) begin
      valid_d = '0;
      short_d = '0;
      long_d  = '0;
    end
    if (fire) begin
      if (!here_sat) begin
        valid_d[slot_q] = 1'b1;
        short_d         = short_q + 1'b1;
        long_d          = long_q + 1'b1;
      end
      if (drop && (total_q != mwrd_pkg::TotalMax)) begin
        total_d = total_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_a) begin
      rd_a_q <= ring_q[rd_addr_a];
      va_q   <= valid_q[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_b_q <= ring_q[rd_addr_b];
      vb_q   <= valid_q[rd_addr_b];
    end
    if (fire && !here_sat) begin
      ring_q[slot_q] <= here + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    if (fire) begin
      out_drop_q  <= drop;
      out_total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwrd_pkg::StIdle;
      valid_q     <= '0;
      ret_pend_q  <= 1'b0;
      short_q     <= '0;
      long_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ret_pend_q  <= ret_pend_d;
      short_q     <= short_d;
      long_q      <= long_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_dropped_o = out_drop_q;
  assign res_total_o   = out_total_q;

endmodule

// ----- src/multi_window_request_dropper.sv -----
// Top level of the multi-window request dropper.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready      | tdata[29:0] request_time
//  m_axis    | out | m_axis_tvalid/tready      | tdata[0] dropped, [24:1] dropped_total
//  cfg       | in  | cfg_valid/cfg_ready       | cfg_addr register index, cfg_data
//
// A request in the same second as the one before goes from the idle state straight to exec.
// A step forward of g seconds (g below LONG_WINDOW) passes through the retire and read states,
// one ring entry retired per cycle over a dual read port; a jump of LONG_WINDOW or more passes through clear and read.
// Ring entries carry valid bits, so reset needs no clearing pass.
// A two-beat queue lets the front accept while the back retires or the output stalls.
`timescale 1ns / 1ps

module multi_window_request_dropper #(
  parameter int unsigned SHORT_WINDOW = 10,
  parameter int unsigned LONG_WINDOW  = 60,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [29:0] request_time
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [0] dropped, [24:1] dropped_total
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mwrd_pkg::CfgAw-1:0]    cfg_addr,
  input  logic [mwrd_pkg::LimitW-1:0]   cfg_data
);

  localparam int unsigned OutPadW = 32 - 1 - mwrd_pkg::TotalW;

  mwrd_pkg::limits_t    limits_q, limits_d;
  mwrd_pkg::req_entry_t push_entry, head_entry;
  logic                 push, full, head_valid, pop;
  logic                 res_dropped;
  logic [mwrd_pkg::TotalW-1:0] res_total;

  assign cfg_ready = 1'b1;

  always_comb begin
    limits_d = limits_q;
    if (cfg_valid) begin
      unique case (mwrd_pkg::cfg_reg_e'(cfg_addr))
        mwrd_pkg::CfgLimitOne:   limits_d.one_sec   = cfg_data;
        mwrd_pkg::CfgLimitShort: limits_d.short_win = cfg_data;
        mwrd_pkg::CfgLimitLong:  limits_d.long_win  = cfg_data;
        default: begin
          limits_d = limits_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.one_sec   <= mwrd_pkg::LimitOneRst;
      limits_q.short_win <= mwrd_pkg::LimitShortRst;
      limits_q.long_win  <= mwrd_pkg::LimitLongRst;
    end else begin
      limits_q <= limits_d;
    end
  end

  mwrd_front #(
    .LONG_WINDOW(LONG_WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_time_i (s_axis_tdata[mwrd_pkg::TimeW-1:0]),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  mwrd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .head_o (head_entry)
  );

  mwrd_back #(
    .SHORT_WINDOW(SHORT_WINDOW),
    .LONG_WINDOW (LONG_WINDOW),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limits_i     (limits_q),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_dropped_o(res_dropped),
    .res_total_o  (res_total)
  );

  assign m_axis_tdata = {{OutPadW{1'b0}}, res_total, res_dropped};

  a_drop_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_dropped |-> res_total != '0)
    else $error("dropped result carries a zero drop total");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> head_valid)
    else $error("accepted request missing from queue");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the multi-window request dropper.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned PhaseItems  = 230;
  localparam int unsigned BurstItems  = 60;
  localparam int unsigned TopTime     = 32'h3FFF_FFFF;
  localparam logic [mwrd_pkg::CfgAw-1:0] CfgNoReg = 2'd3;

  class drop_ledger;
    localparam int unsigned ShortWin   = 10;
    localparam int unsigned LongWin    = 60;
    localparam int unsigned CountMax   = 32'h0000_FFFF;

    typedef struct packed {
      logic                              dropped;
      logic [mwrd_pkg::TotalW-1:0] total;
    } verdict_t;

    int unsigned lim_one;
    int unsigned lim_short;
    int unsigned lim_long;
    int unsigned sec_count[mwrd_pkg::RingDepth];
    int unsigned latest;
    int unsigned short_total;
    int unsigned long_total;
    int unsigned drop_total;
    verdict_t    verdicts_due[$];
    int unsigned errors;

    function new();
      lim_one     = 32'(mwrd_pkg::LimitOneRst);
      lim_short   = 32'(mwrd_pkg::LimitShortRst);
      lim_long    = 32'(mwrd_pkg::LimitLongRst);
      foreach (sec_count[i]) sec_count[i] = 0;
      latest      = 0;
      short_total = 0;
      long_total  = 0;
      drop_total  = 0;
      errors      = 0;
    endfunction

    function void set_limit(logic [mwrd_pkg::CfgAw-1:0] idx,
                            logic [mwrd_pkg::LimitW-1:0] val);
      case (idx)
        mwrd_pkg::CfgLimitOne:   lim_one = 32'(val);
        mwrd_pkg::CfgLimitShort: lim_short = 32'(val);
        mwrd_pkg::CfgLimitLong:  lim_long = 32'(val);
        default: ;
      endcase
    endfunction

    // retire the seconds that leave each window
    function void roll_forward(int unsigned now);
      int unsigned gap;
      int unsigned s;
      gap = now - latest;
      if (gap >= LongWin) begin
        foreach (sec_count[i]) sec_count[i] = 0;
        short_total = 0;
        long_total  = 0;
      end else begin
        for (int unsigned k = 1; k <= gap; k++) begin
          s = latest + k;
          short_total -= sec_count[(s - ShortWin) % mwrd_pkg::RingDepth];
          long_total  -= sec_count[(s - LongWin) % mwrd_pkg::RingDepth];
          sec_count[s % mwrd_pkg::RingDepth] = 0;
        end
      end
      latest = now;
    endfunction

    function void note_request(logic [mwrd_pkg::TimeW-1:0] t);
      int unsigned slot;
      int unsigned here;
      logic        drop;
      verdict_t    v;
      if (32'(t) > latest) roll_forward(32'(t));
      slot = latest % mwrd_pkg::RingDepth;
      here = sec_count[slot];
      drop = (here + 1 > lim_one) || (short_total + 1 > lim_short) ||
             (long_total + 1 > lim_long);
      if (here < CountMax) begin
        sec_count[slot] = here + 1;
        short_total++;
        long_total++;
      end
      if (drop && drop_total < 32'(mwrd_pkg::TotalMax)) drop_total++;
      v.dropped = drop;
      v.total   = mwrd_pkg::TotalW'(drop_total);
      verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      errors++;
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_verdict(logic [31:0] beat);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        report("unexpected result beat", beat, 0);
      end else begin
        want = verdicts_due.pop_front();
        if (beat[0] !== want.dropped) report("dropped", 32'(beat[0]), 32'(want.dropped));
        if (beat[24:1] !== want.total) begin
          report("dropped_total", 32'(beat[24:1]), 32'(want.total));
        end
      end
    endtask

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [31:0]                   s_axis_tdata = '0;   // [29:0] request_time
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [31:0]                   m_axis_tdata;        // [0] dropped, [24:1] dropped_total
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mwrd_pkg::CfgAw-1:0]    cfg_addr = '0;
  logic [mwrd_pkg::LimitW-1:0]   cfg_data = '0;

  drop_ledger  ledger = new();
  int unsigned quiet_cycles = 0;
  int unsigned clock_now = 0;
  bit          steady = 1'b0;
  bit          hold_off = 1'b0;

  multi_window_request_dropper u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) ledger.set_limit(cfg_addr, cfg_data);
      if (s_axis_tvalid && s_axis_tready) begin
        ledger.note_request(s_axis_tdata[mwrd_pkg::TimeW-1:0]);
      end
      if (m_axis_tvalid && m_axis_tready) ledger.check_verdict(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < QuietLimit);
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls, free running, or a long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  function automatic int unsigned next_second(int unsigned now);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return now;
    if (pick < 78) return now + $urandom_range(3, 1);
    if (pick < 88) return now + $urandom_range(15, 4);
    if (pick < 94) return now + $urandom_range(70, 16);
    if (pick < 96) return now + $urandom_range(1 << 20, 71);
    return $urandom_range(now, 1);
  endfunction

  task automatic send_request(input int unsigned t);
    while (!steady && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t[mwrd_pkg::TimeW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (t > clock_now) clock_now = t;
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_request(next_second(clock_now));
  endtask

  // hold the sender until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  task automatic set_limits(input logic [mwrd_pkg::LimitW-1:0] one_lim,
                            input logic [mwrd_pkg::LimitW-1:0] short_lim,
                            input logic [mwrd_pkg::LimitW-1:0] long_lim,
                            input bit stray);
    logic [mwrd_pkg::CfgAw-1:0]  idx[4];
    logic [mwrd_pkg::LimitW-1:0] val[4];
    int                          first;
    idx   = '{CfgNoReg, mwrd_pkg::CfgLimitOne, mwrd_pkg::CfgLimitShort,
              mwrd_pkg::CfgLimitLong};
    val   = '{16'hFFFF, one_lim, short_lim, long_lim};
    first = stray ? 0 : 1;
    for (int i = first; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned directed[$];
    int unsigned top_run[$];
    directed = '{1, 1, 1, 1, 2, 1, 5, 12, 12, 21, 80, 139, 199, 199, 200};
    top_run  = '{TopTime - 70, TopTime - 11, TopTime - 1, TopTime, TopTime, 3};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    set_limits(16'h0000, 16'h0000, 16'h0000, 1'b1);
    run_random(40);
    drain();

    // pile requests into one second, then walk it out of both windows
    set_limits(16'd40, 16'd50, 16'd90, 1'b0);
    steady = 1'b1;
    for (int unsigned i = 0; i < BurstItems; i++) begin
      send_request(clock_now + ((i == 0) ? 1 : 0));
    end
    send_request(clock_now + 3);
    send_request(clock_now);
    send_request(clock_now + 12);
    send_request(clock_now + 50);
    steady = 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        4: set_limits(16'hFFFF, mwrd_pkg::LimitW'($urandom_range(40, 10)), 16'hFFFF, 1'b0);
        5: set_limits(16'd2, 16'hFFFF, mwrd_pkg::LimitW'($urandom_range(60, 20)), 1'b1);
        default: set_limits(mwrd_pkg::LimitW'($urandom_range(6, 1)),
                            mwrd_pkg::LimitW'($urandom_range(30, 2)),
                            mwrd_pkg::LimitW'($urandom_range(120, 5)), 1'b0);
      endcase
      steady = (ph == 3);
      if (ph == 1) begin
        run_random(20);
        hold_off = 1'b1;
        run_random(PhaseItems - 20);
      end else begin
        run_random(PhaseItems);
      end
      drain();
    end
    steady = 1'b0;

    set_limits(16'd3, 16'd20, 16'd60, 1'b0);
    foreach (top_run[i]) send_request(top_run[i]);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- multi_window_request_dropper.f -----
src/mwrd_pkg.sv
src/mwrd_front.sv
src/mwrd_fifo.sv
src/mwrd_back.sv
src/multi_window_request_dropper.sv
tb/tb_top.sv
